@@ src/assert_macros.svh @@
// Assertion macros shared by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ src/spq_pkg.sv @@
// Shared constants and types of the stable priority queue.
package spq_pkg;

  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefPrioBits = 3;
  localparam int unsigned DefIdBits   = 16;

  // Item kinds on the input tuser
  localparam logic KindInsert = 1'b0;
  localparam logic KindGet    = 1'b1;

  // Result status codes on the output tuser
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic get;
  } spq_op_t;

endpackage

@@ src/spq_cell.sv @@
// One cell of the sorted shift-register queue: holds one entry slot.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned IDX       = 0,
  parameter int unsigned PRIO_BITS = DefPrioBits,
  parameter int unsigned ID_BITS   = DefIdBits,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  spq_op_t              op_i,
  input  logic [CntW-1:0]      count_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic                 left_pass_i,
  input  logic [PRIO_BITS-1:0] left_prio_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [PRIO_BITS-1:0] right_prio_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  output logic                 pass_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic [ID_BITS-1:0]   id_o
);

  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic                 occupied;

  assign occupied = count_i > CntW'(IDX);
  // At or behind the insertion point: empty, or holding a strictly larger number
  assign pass_o   = !(occupied && (prio_q <= new_prio_i));

  always_comb begin
    prio_d = prio_q;
    id_d   = id_q;
    if (op_i.ins && pass_o) begin
      if (left_pass_i) begin
        prio_d = left_prio_i;
        id_d   = left_id_i;
      end else begin
        prio_d = new_prio_i;
        id_d   = new_id_i;
      end
    end else if (op_i.get) begin
      prio_d = right_prio_i;
      id_d   = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    id_q   <= id_d;
  end

  assign prio_o = prio_q;
  assign id_o   = id_q;

endmodule

@@ src/stable_priority_queue_core.sv @@
// Stable priority queue: a row of DEPTH cells kept sorted by priority number
// (lowest first, equal numbers in arrival order). The block takes one item
// per clock cycle unless the output stalls: on an insert every cell compares
// the new priority with its own entry and the cells behind the insertion
// point shift back by one; on a get every cell takes its right neighbor's
// entry. An item's result appears in the output register in the cycle after
// the item is accepted; the input stalls only while that register holds a
// result that has not been taken. Every item yields exactly one result.
// Queue entries carry no reset; only the occupied slots are ever read.
`include "assert_macros.svh"

module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned PRIO_BITS = DefPrioBits,
  parameter int unsigned ID_BITS   = DefIdBits,
  localparam int unsigned CntW     = $clog2(DEPTH + 1),
  localparam int unsigned InW      = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
  localparam int unsigned OutW     = ((ID_BITS + PRIO_BITS + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,  // entry_id, entry_priority, zero fill
  input  logic            s_axis_tuser_i,  // kind
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,  // out_id, out_priority, occupancy, zero fill
  output logic [1:0]      m_axis_tuser_o   // status
);

  logic                 in_accept;
  logic [ID_BITS-1:0]   new_id;
  logic [PRIO_BITS-1:0] new_prio;
  logic                 full, empty;
  spq_op_t              op;

  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [ID_BITS-1:0]   out_id_q, out_id_d;
  logic [PRIO_BITS-1:0] out_prio_q, out_prio_d;
  logic [CntW-1:0]      out_occ_q, out_occ_d;

  logic [DEPTH-1:0]     cell_pass;
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [ID_BITS-1:0]   cell_id   [DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign new_id          = s_axis_tdata_i[ID_BITS-1:0];
  assign new_prio        = s_axis_tdata_i[ID_BITS +: PRIO_BITS];
  assign full            = count_q == CntW'(DEPTH);
  assign empty           = count_q == '0;

  always_comb begin
    op.ins = in_accept && (s_axis_tuser_i == KindInsert) && !full;
    op.get = in_accept && (s_axis_tuser_i == KindGet) && !empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_pass;
    logic [PRIO_BITS-1:0] left_prio, right_prio;
    logic [ID_BITS-1:0]   left_id, right_id;

    if (i == 0) begin : g_head
      assign left_pass = 1'b0;
      assign left_prio = '0;
      assign left_id   = '0;
    end else begin : g_mid
      assign left_pass = cell_pass[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_id   = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_id   = '0;
    end else begin : g_body
      assign right_prio = cell_prio[i+1];
      assign right_id   = cell_id[i+1];
    end

    spq_cell #(
      .DEPTH    (DEPTH),
      .IDX      (i),
      .PRIO_BITS(PRIO_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .count_i     (count_q),
      .new_prio_i  (new_prio),
      .new_id_i    (new_id),
      .left_pass_i (left_pass),
      .left_prio_i (left_prio),
      .left_id_i   (left_id),
      .right_prio_i(right_prio),
      .right_id_i  (right_id),
      .pass_o      (cell_pass[i]),
      .prio_o      (cell_prio[i]),
      .id_o        (cell_id[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_prio_d   = out_prio_q;
    out_occ_d    = out_occ_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.get) begin
      count_d = count_q - CntW'(1);
    end
    if (in_accept) begin
      out_valid_d  = 1'b1;
      out_id_d     = '0;
      out_prio_d   = '0;
      out_occ_d    = count_d;
      if (s_axis_tuser_i == KindGet) begin
        if (empty) begin
          out_status_d = StEmpty;
        end else begin
          out_status_d = StOk;
          out_id_d     = cell_id[0];
          out_prio_d   = cell_prio[0];
        end
      end else begin
        out_status_d = full ? StFull : StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: loaded on accept only
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_prio_q   <= out_prio_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutW'({out_occ_q, out_prio_q, out_id_q});

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH))
  `SPQ_ASSERT_IMPL(a_occ_matches, clk_i, rst_ni, out_valid_q, out_occ_q == count_q)
  `SPQ_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, op.ins,
                   count_q == $past(count_q) + CntW'(1))
  `SPQ_ASSERT_NEXT(a_get_shrinks, clk_i, rst_ni, op.get,
                   count_q == $past(count_q) - CntW'(1))

  for (genvar i = 1; i < DEPTH; i++) begin : g_order_chk
    `SPQ_ASSERT_IMPL(a_sorted, clk_i, rst_ni, count_q > CntW'(i),
                     cell_prio[i-1] <= cell_prio[i])
  end

endmodule

@@ verif/spq_checker.sv @@
// Scoreboard for the stable priority queue: predicts every result and compares it.
module spq_checker
  import spq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [23:0]           s_tdata_i,   // entry_id, entry_priority, zero fill
  input  logic                  s_tuser_i,   // kind
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [23:0]           m_tdata_i,   // out_id, out_priority, occupancy
  input  logic [1:0]            m_tuser_i,   // status
  output int                    fail_count_o,
  output int                    open_results_o
);

  localparam int unsigned CntW = $clog2(DefDepth + 1);

  typedef struct packed {
    logic [DefPrioBits-1:0] prio;
    logic [DefIdBits-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [DefIdBits-1:0]   id;
    logic [DefPrioBits-1:0] prio;
    logic [CntW-1:0]        occupancy;
  } outcome_t;

  // Sorted model of the queue contents, head at index 0
  entry_t   held_entries[$];
  outcome_t expected_outcomes[$];

  function automatic outcome_t queue_outcome(input logic kind,
                                             input logic [DefIdBits-1:0] id,
                                             input logic [DefPrioBits-1:0] prio);
    outcome_t r;
    entry_t   e;
    int       pos;
    r.status    = StOk;
    r.id        = '0;
    r.prio      = '0;
    r.occupancy = '0;
    if (kind == KindGet) begin
      if (held_entries.size() == 0) begin
        r.status = StEmpty;
      end else begin
        e      = held_entries.pop_front();
        r.id   = e.id;
        r.prio = e.prio;
      end
    end else if (held_entries.size() >= DefDepth) begin
      r.status = StFull;
    end else begin
      // place behind every entry of equal or better priority
      pos = 0;
      while (pos < held_entries.size() && held_entries[pos].prio <= prio) pos++;
      e.prio = prio;
      e.id   = id;
      held_entries.insert(pos, e);
    end
    r.occupancy = CntW'(held_entries.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      fail_count_o   = 0;
      open_results_o = 0;
      held_entries.delete();
      expected_outcomes.delete();
    end else begin
      // a result can only belong to an item accepted at an earlier edge: check first
      if (m_tvalid_i && m_tready_i) begin
        got.status    = m_tuser_i;
        got.id        = m_tdata_i[DefIdBits-1:0];
        got.prio      = m_tdata_i[DefIdBits +: DefPrioBits];
        got.occupancy = m_tdata_i[DefIdBits+DefPrioBits +: CntW];
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%h prio=%0d occ=%0d",
                   $time, got.status, got.id, got.prio, got.occupancy);
          fail_count_o++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status || got.id !== want.id ||
              got.prio !== want.prio || got.occupancy !== want.occupancy) begin
            $display({"%0t: mismatch expected status=%0d id=%h prio=%0d occ=%0d",
                      " actual status=%0d id=%h prio=%0d occ=%0d"},
                     $time, want.status, want.id, want.prio, want.occupancy,
                     got.status, got.id, got.prio, got.occupancy);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_outcomes.push_back(queue_outcome(s_tuser_i, s_tdata_i[DefIdBits-1:0],
                                                  s_tdata_i[DefIdBits +: DefPrioBits]));
      open_results_o = expected_outcomes.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Top of the stable priority queue testbench: clock, reset, stimulus and verdict.
module tb_top;
  import spq_pkg::*;

  localparam int unsigned CntW       = $clog2(DefDepth + 1);
  localparam int unsigned InW        = ((DefIdBits + DefPrioBits + 7) / 8) * 8;
  localparam int unsigned OutW       = ((DefIdBits + DefPrioBits + CntW + 7) / 8) * 8;
  localparam int unsigned FillW      = InW - DefIdBits - DefPrioBits;
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned CycleLimit = 400000;

  logic            clk;
  logic            rst_n;
  logic            s_valid;
  logic            s_ready;
  logic [InW-1:0]  s_data;
  logic            s_user;
  logic            m_valid;
  logic            m_ready;
  logic [OutW-1:0] m_data;
  logic [1:0]      m_user;

  int fail_count;
  int open_results;
  int cycle_count = 0;
  int src_idle    = 0;
  int sink_stall  = 0;

  stable_priority_queue_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  spq_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_tvalid_i     (s_valid),
    .s_tready_i     (s_ready),
    .s_tdata_i      (s_data),
    .s_tuser_i      (s_user),
    .m_tvalid_i     (m_valid),
    .m_tready_i     (m_ready),
    .m_tdata_i      (m_data),
    .m_tuser_i      (m_user),
    .fail_count_o   (fail_count),
    .open_results_o (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) m_ready <= ($urandom_range(99, 0) >= sink_stall);

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic send_item(input logic kind, input logic [DefIdBits-1:0] id,
                           input logic [DefPrioBits-1:0] prio);
    while ($urandom_range(99, 0) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {{FillW{1'b0}}, prio, id};
    do @(posedge clk); while (!s_ready);
  endtask

  initial begin
    int phase_src[4];
    int phase_sink[4];
    int insert_pct;
    int prio_lo;
    int prio_hi;
    logic kind;
    logic [DefIdBits-1:0] id;
    phase_src  = '{0, 65, 0, 30};
    phase_sink = '{0, 0, 65, 30};
    s_valid <= 1'b0;
    s_user  <= KindInsert;
    s_data  <= '0;
    rst_n   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // get on empty, id and priority extremes, ties, fill up, drop on full, drain a few
    send_item(KindGet, 16'h0000, 3'd0);
    send_item(KindInsert, 16'h0000, 3'd7);
    send_item(KindInsert, 16'hFFFF, 3'd0);
    send_item(KindInsert, 16'h1111, 3'd3);
    send_item(KindInsert, 16'h2222, 3'd3);
    send_item(KindInsert, 16'h3333, 3'd0);
    send_item(KindInsert, 16'h4444, 3'd7);
    for (int i = 0; i < 10; i++)
      send_item(KindInsert, DefIdBits'(16'hA000 + i), DefPrioBits'(i % 8));
    send_item(KindInsert, 16'h5555, 3'd0);
    repeat (4) send_item(KindGet, 16'hFFFF, 3'd7);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle   = phase_src[ph];
      sink_stall = phase_sink[ph];
      for (int n = 0; n < RandItems / 4; n++) begin
        // swing between filling and draining, with narrow priority bands for ties
        if (n % 40 == 0) begin
          case ($urandom_range(2, 0))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
          endcase
          if ($urandom_range(1, 0)) begin
            prio_lo = 0;
            prio_hi = 7;
          end else begin
            prio_lo = $urandom_range(6, 0);
            prio_hi = prio_lo + 1;
          end
        end
        kind = ($urandom_range(99, 0) < insert_pct) ? KindInsert : KindGet;
        if ($urandom_range(15, 0) == 0)
          id = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
        else
          id = DefIdBits'($urandom_range(65535, 0));
        send_item(kind, id, DefPrioBits'($urandom_range(prio_hi, prio_lo)));
      end
    end
    s_valid <= 1'b0;

    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
